// ===== src/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg: shared types for the integer literal parser
// Character classes, the queued item format, radix codes and parser phases.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

	// character classes as seen by the parser back end
	typedef enum logic [2:0] {
		CL_PLUS  = 3'd0,
		CL_MINUS = 3'd1,
		CL_APOS  = 3'd2,
		CL_STOP  = 3'd3,
		CL_DIGIT = 3'd4,
		CL_BAD   = 3'd5
	} char_class_t;

	// one classified character as it travels through the queue
	typedef struct packed {
		char_class_t cls;
		logic [5:0]  digit;   // digit worth 0..35, valid for CL_DIGIT
		logic        is_x;    // lowercase x
		logic        is_b;    // lowercase b
		logic        last;
	} ilp_item_t;

	// radix codes
	typedef enum logic [1:0] {
		RAD_DEC = 2'd0,
		RAD_HEX = 2'd1,
		RAD_OCT = 2'd2,
		RAD_BIN = 2'd3
	} radix_t;

	// parser phases, one-hot
	typedef enum logic [5:0] {
		PH_START      = 6'b000001,
		PH_AFTER_SIGN = 6'b000010,
		PH_ZERO       = 6'b000100,
		PH_BODY       = 6'b001000,
		PH_STOPPED    = 6'b010000,
		PH_FAILED     = 6'b100000
	} phase_t;

	// queue depth between front and back, a power of two
	localparam int unsigned QDEPTH = 4;

endpackage

`default_nettype wire

// ===== src/ilp_front.sv =====
// ----------------------------------------------------------------------------
// ilp_front: input side of the parser
// Takes character beats and classifies each byte into a queue item.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_front (
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        char_code,
	input  wire logic              is_last,
	input  wire logic              q_full,
	output logic                   push,
	output ilp_pkg::ilp_item_t     item
);
	import ilp_pkg::*;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_RBRC  = 8'h7D;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	logic [7:0] c_dig;
	logic [7:0] c_lo;
	logic [7:0] c_up;

	// beat handshake into the queue
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// digit offsets for each range
	assign c_dig = char_code - CH_0;
	assign c_lo  = char_code - CH_LO_A + 8'd10;
	assign c_up  = char_code - CH_UP_A + 8'd10;

	// classify the byte, stop and apostrophe ahead of letters
	always_comb begin
		item.digit = '0;
		item.is_x  = (char_code == CH_LO_X);
		item.is_b  = (char_code == CH_LO_B);
		item.last  = is_last;
		priority if (char_code == CH_PLUS) begin
			item.cls = CL_PLUS;
		end else if (char_code == CH_MINUS) begin
			item.cls = CL_MINUS;
		end else if (char_code == CH_APOS) begin
			item.cls = CL_APOS;
		end else if (char_code == CH_COMMA || char_code == CH_SPACE ||
		             char_code == CH_RBRK || char_code == CH_RBRC ||
		             char_code == CH_LO_L || char_code == CH_UP_L ||
		             char_code == CH_LO_U || char_code == CH_UP_U) begin
			item.cls = CL_STOP;
		end else if (char_code >= CH_0 && char_code <= CH_9) begin
			item.cls   = CL_DIGIT;
			item.digit = c_dig[5:0];
		end else if (char_code >= CH_LO_A && char_code <= CH_LO_Z) begin
			item.cls   = CL_DIGIT;
			item.digit = c_lo[5:0];
		end else if (char_code >= CH_UP_A && char_code <= CH_UP_Z) begin
			item.cls   = CL_DIGIT;
			item.digit = c_up[5:0];
		end else begin
			item.cls = CL_BAD;
		end
	end

endmodule

`default_nettype wire

// ===== src/ilp_queue.sv =====
// ----------------------------------------------------------------------------
// ilp_queue: short item queue between front and back
// Register-based FIFO so that front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ilp_pkg::ilp_item_t wr_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    rd_valid,
	output ilp_pkg::ilp_item_t      rd_item
);
	import ilp_pkg::*;

	localparam int unsigned PW = $clog2(QDEPTH);
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	ilp_item_t       mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count, pointers wrap naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// fill count stays within the depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QDEPTH))
		else $error("queue count beyond depth");

	// never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("queue popped while empty");

	// never push a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue pushed while full");

endmodule

`default_nettype wire

// ===== src/ilp_back.sv =====
// ----------------------------------------------------------------------------
// ilp_back: parser state machine and accumulator
// Consumes one item per cycle, a last one only into a free result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_back #(
	parameter int unsigned MAX_CHARS = 255
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire ilp_pkg::ilp_item_t q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [63:0]             value,
	output logic [7:0]              consumed,
	output logic                    ok
);
	import ilp_pkg::*;

	localparam int unsigned CW = $clog2(MAX_CHARS + 1);

	phase_t         phase_q, phase_d;
	radix_t         radix_q, radix_d, radix_eff;
	logic [63:0]    acc_q, acc_d, mac;
	logic           neg_q, neg_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic           cnt_inc;
	logic           do_body;
	logic [5:0]     base;
	logic           is_zero;
	logic           good;
	logic [CW+7:0]  cnt_ext;
	logic           pop_last;

	logic           out_valid_q;
	logic [63:0]    value_q;
	logic [7:0]     consumed_q;
	logic           ok_q;

	// pop any queued item; a last one only when the output register can take it
	assign pop      = q_valid && (!q_item.last || !out_valid_q || out_ready);
	assign pop_last = pop && q_item.last;
	assign is_zero  = (q_item.cls == CL_DIGIT) && (q_item.digit == '0);

	// radix the body logic works in for the current item
	always_comb begin
		priority if (phase_q == PH_START || phase_q == PH_AFTER_SIGN) begin
			radix_eff = RAD_DEC;
		end else if (phase_q == PH_ZERO) begin
			radix_eff = RAD_OCT;
		end else begin
			radix_eff = radix_q;
		end
	end

	// base of the effective radix
	always_comb begin
		unique case (radix_eff)
			RAD_DEC: base = 6'd10;
			RAD_HEX: base = 6'd16;
			RAD_OCT: base = 6'd8;
			RAD_BIN: base = 6'd2;
			default: base = 6'd10;
		endcase
	end

	// multiply-add by shifts, digit is below the base when used
	always_comb begin
		unique case (radix_eff)
			RAD_DEC: mac = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} +
			               {58'd0, q_item.digit};
			RAD_HEX: mac = {acc_q[59:0], q_item.digit[3:0]};
			RAD_OCT: mac = {acc_q[60:0], q_item.digit[2:0]};
			RAD_BIN: mac = {acc_q[62:0], q_item.digit[0]};
			default: mac = acc_q;
		endcase
	end

	// next-state logic of the parser
	always_comb begin
		phase_d   = phase_q;
		radix_d   = radix_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		cnt_inc   = 1'b0;
		do_body   = 1'b0;
		unique case (phase_q)
			PH_START, PH_AFTER_SIGN: begin
				if (phase_q == PH_START &&
				    (q_item.cls == CL_PLUS || q_item.cls == CL_MINUS)) begin
					neg_d   = (q_item.cls == CL_MINUS);
					cnt_inc = 1'b1;
					phase_d = q_item.last ? PH_FAILED : PH_AFTER_SIGN;
				end else if (is_zero && !q_item.last) begin
					cnt_inc = 1'b1;
					phase_d = PH_ZERO;
				end else begin
					radix_d   = RAD_DEC;
					do_body   = 1'b1;
				end
			end
			PH_ZERO: begin
				if ((q_item.is_x || q_item.is_b) && !q_item.last) begin
					radix_d = q_item.is_x ? RAD_HEX : RAD_BIN;
					cnt_inc = 1'b1;
					phase_d = PH_BODY;
				end else begin
					radix_d   = RAD_OCT;
					do_body   = 1'b1;
				end
			end
			PH_BODY: begin
				do_body = 1'b1;
			end
			default: begin
				// stopped or failed: ignore bytes until the last one
			end
		endcase

		// number body in the effective radix
		if (do_body) begin
			unique case (q_item.cls)
				CL_APOS: begin
					cnt_inc = 1'b1;
					phase_d = PH_BODY;
				end
				CL_STOP: begin
					phase_d = PH_STOPPED;
				end
				CL_DIGIT: begin
					if (q_item.digit >= base) begin
						phase_d = PH_FAILED;
					end else begin
						acc_d   = mac;
						cnt_inc = 1'b1;
						phase_d = PH_BODY;
					end
				end
				default: begin
					phase_d = PH_FAILED;
				end
			endcase
		end

		// saturating character count
		cnt_d = (cnt_inc && cnt_q < CW'(MAX_CHARS)) ? cnt_q + 1'b1 : cnt_q;
	end

	assign good    = (phase_d != PH_FAILED) && (cnt_d != '0);
	assign cnt_ext = {8'd0, cnt_d};

	// parser state, back to start after each last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RAD_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (pop_last) begin
			phase_q <= PH_START;
			radix_q <= RAD_DEC;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			cnt_q   <= cnt_d;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (pop_last) begin
			ok_q <= good;
			if (good) begin
				value_q    <= neg_d ? (64'd0 - acc_d) : acc_d;
				consumed_q <= (cnt_ext > (CW + 8)'(255)) ? 8'hFF : cnt_ext[7:0];
			end else begin
				value_q    <= '0;
				consumed_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign consumed  = consumed_q;
	assign ok        = ok_q;

	// a last beat leaves the parser at the start of a fresh literal
	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop_last |=> phase_q == PH_START && acc_q == '0 && cnt_q == '0 && !neg_q)
		else $error("parser state not cleared after last beat");

	// a failed result carries zero value and count
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> value_q == '0 && consumed_q == '0)
		else $error("failed result with nonzero payload");

	// a good result always consumed something
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ok_q |-> consumed_q != '0)
		else $error("good result with zero count");

	// after a stop or failure the accumulator holds
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !q_item.last && (phase_q == PH_STOPPED || phase_q == PH_FAILED)
		|=> $stable(acc_q))
		else $error("accumulator moved after stop or failure");

endmodule

`default_nettype wire

// ===== src/integer_literal_parser_core.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parser_core: streaming integer literal parser
// One character per beat in; one value/count/ok beat out per literal.
// ----------------------------------------------------------------------------
// throughput: one character per cycle while the queue has room and no last
//   character waits on a busy output register; the shift-add accumulator in
//   the back end is combinational; result path: the last character is written
//   into the queue, then popped by the back end into the output register that
//   drives the result beat; earlier items or a busy output register can stall it
// reset: asynchronous, clears the queue, parser state and result valid;
//   no clearing pass, items are taken right after reset
`default_nettype none

module integer_literal_parser_core #(
	parameter int unsigned MAX_CHARS = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      value,
	output logic [7:0]       consumed,
	output logic             ok
);
	import ilp_pkg::*;

	ilp_item_t f_item;
	ilp_item_t q_item;
	logic      push;
	logic      q_full;
	logic      q_valid;
	logic      pop;

	// classify incoming characters
	ilp_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.is_last   (is_last),
		.q_full    (q_full),
		.push      (push),
		.item      (f_item)
	);

	// decoupling queue
	ilp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	// parse and accumulate
	ilp_back #(
		.MAX_CHARS (MAX_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.consumed  (consumed),
		.ok        (ok)
	);

endmodule

`default_nettype wire
